[src/sm2r_pkg.sv]
// Shared constants, types and a helper function for the SM2 P-256 fast reduction pipeline.
package sm2r_pkg;

   localparam int LIMB_W  = 64;
   localparam int WORD_W  = 32;
   localparam int NWORDS  = 8;
   localparam int LO_W    = WORD_W * NWORDS;
   localparam int IN_W    = 2 * LO_W;
   localparam int COL_W   = WORD_W + 6;
   localparam int CARRY_W = 8;
   localparam int TOT_W   = LO_W + CARRY_W;

   localparam logic [LO_W-1:0] PRIME = {
      64'hfffffffeffffffff, 64'hffffffffffffffff,
      64'hffffffff00000000, 64'hffffffffffffffff
   };

   localparam logic [IN_W-1:0] PRIME_SQ = {
      64'hfffffffe00000000, 64'hffffffffffffffff,
      64'hfffffffe00000003, 64'hfffffffdfffffffe,
      64'h0000000200000000, 64'hfffffffe00000001,
      64'h00000001fffffffe, 64'h0000000000000001
   };

   // Signed multiple of upper word (8 + j) that lands in lower word i.
   localparam int WEIGHT [NWORDS][NWORDS] = '{
      '{ 1,  1, 1, 1, 1,  2,  2, 2},
      '{ 0,  1, 1, 1, 1,  1,  2, 2},
      '{-1, -1, 0, 0, 0, -1, -1, 0},
      '{ 1,  0, 0, 1, 1,  2,  1, 1},
      '{ 0,  1, 0, 0, 1,  1,  2, 1},
      '{ 0,  0, 1, 0, 0,  1,  1, 2},
      '{ 0,  0, 0, 1, 0,  0,  1, 1},
      '{ 1,  1, 1, 1, 2,  2,  2, 3}
   };

   typedef logic signed [COL_W-1:0] col_type;
   typedef logic signed [TOT_W-1:0] total_type;
   typedef logic [LO_W-1:0] residue_type;

   // Folds the signed carry above bit 255 back into the low 256 bits.
   function automatic total_type fold_carry(input total_type t);
      logic signed [CARRY_W-1:0] c;
      total_type ce;
      total_type acc;
      total_type sh;
      c   = t[TOT_W-1:LO_W];
      ce  = total_type'(c);
      acc = total_type'({{CARRY_W{1'b0}}, t[LO_W-1:0]});
      for (int i = 0; i < NWORDS; i++) begin
         sh = ce <<< (WORD_W * i);
         case (WEIGHT[i][0])
            1: acc = acc + sh;
            2: acc = acc + (sh <<< 1);
            3: acc = acc + (sh <<< 1) + sh;
            -1: acc = acc - sh;
            -2: acc = acc - (sh <<< 1);
            -3: acc = acc - (sh <<< 1) - sh;
            default: acc = acc;
         endcase
      end
      return acc;
   endfunction

endpackage

[src/sm2_p256_fast_reduction.sv]
// Top level of the SM2 P-256 fast modular reduction pipeline.
// An accepted request passes through each stage register in turn; throughput is one request
// per clock cycle unless rsp_ready holds back a full pipeline. The five stages are column sums, carry
// resolution, two carry folds, and the final subtraction of p into the output register.
// Each stage stalls only when it and every stage after it hold data, so bubbles fill up.
// Reset clears the stage valid bits only; the data registers are not reset.
module sm2_p256_fast_reduction
   import sm2r_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [LIMB_W-1:0] req_value_limb0,
   input  logic [LIMB_W-1:0] req_value_limb1,
   input  logic [LIMB_W-1:0] req_value_limb2,
   input  logic [LIMB_W-1:0] req_value_limb3,
   input  logic [LIMB_W-1:0] req_value_limb4,
   input  logic [LIMB_W-1:0] req_value_limb5,
   input  logic [LIMB_W-1:0] req_value_limb6,
   input  logic [LIMB_W-1:0] req_value_limb7,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [LIMB_W-1:0] rsp_residue_limb0,
   output logic [LIMB_W-1:0] rsp_residue_limb1,
   output logic [LIMB_W-1:0] rsp_residue_limb2,
   output logic [LIMB_W-1:0] rsp_residue_limb3,
   output logic              rsp_out_of_range
);

   localparam int NSTAGES = 5;

   logic [IN_W-1:0]    value;
   logic [NSTAGES:0]   adv;
   logic [NSTAGES-1:0] valid_ff;
   logic [NSTAGES-1:0] valid_in;
   logic [NSTAGES-1:0] oor_ff;
   logic [NSTAGES-1:0] oor_in;

   col_type     col_in [NWORDS];
   col_type     col_ff [NWORDS];
   total_type   tot1_in;
   total_type   tot1_ff;
   total_type   tot2_in;
   total_type   tot2_ff;
   total_type   tot3_in;
   total_type   tot3_ff;
   residue_type res_in;
   residue_type res_ff;

   logic [TOT_W-1:0] lows;
   logic [TOT_W-1:0] highs;
   logic [TOT_W-1:0] signs;
   logic [LO_W:0]    diff;

   assign value = {req_value_limb7, req_value_limb6, req_value_limb5, req_value_limb4,
                   req_value_limb3, req_value_limb2, req_value_limb1, req_value_limb0};

   always_comb begin
      adv[NSTAGES] = rsp_ready;
      for (int k = NSTAGES - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_ready = adv[0];

   always_comb begin
      valid_in = {valid_ff[NSTAGES-2:0], req_valid};
      oor_in   = {oor_ff[NSTAGES-2:0], (value >= PRIME_SQ)};
   end

   sm2r_column_sum u_column_sum (
      .value (value),
      .col   (col_in)
   );

   // Resolve the column carries: each column's top six bits land one word higher.
   always_comb begin
      lows  = '0;
      highs = '0;
      signs = '0;
      for (int i = 0; i < NWORDS; i++) begin
         lows[WORD_W*i +: WORD_W]       = col_ff[i][WORD_W-1:0];
         highs[WORD_W*(i+1) +: 6]       = col_ff[i][COL_W-1:WORD_W];
         signs[WORD_W*(i+1) + 6]        = col_ff[i][COL_W-1];
      end
      tot1_in = total_type'(lows + highs - signs);
   end

   assign tot2_in = fold_carry(tot1_ff);
   assign tot3_in = fold_carry(tot2_ff);

   always_comb begin
      diff = {1'b0, tot3_ff[LO_W-1:0]} - {1'b0, PRIME};
      if (oor_ff[3]) begin
         res_in = '0;
      end else if (!diff[LO_W]) begin
         res_in = diff[LO_W-1:0];
      end else begin
         res_in = tot3_ff[LO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTAGES; k++) begin
         if (adv[k]) begin
            oor_ff[k] <= oor_in[k];
         end
      end
      if (adv[0]) begin
         col_ff <= col_in;
      end
      if (adv[1]) begin
         tot1_ff <= tot1_in;
      end
      if (adv[2]) begin
         tot2_ff <= tot2_in;
      end
      if (adv[3]) begin
         tot3_ff <= tot3_in;
      end
      if (adv[4]) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid         = valid_ff[NSTAGES-1];
   assign rsp_out_of_range  = oor_ff[NSTAGES-1];
   assign rsp_residue_limb0 = res_ff[LIMB_W*0 +: LIMB_W];
   assign rsp_residue_limb1 = res_ff[LIMB_W*1 +: LIMB_W];
   assign rsp_residue_limb2 = res_ff[LIMB_W*2 +: LIMB_W];
   assign rsp_residue_limb3 = res_ff[LIMB_W*3 +: LIMB_W];

endmodule

[src/sm2r_column_sum.sv]
// Weighted signed column sums that fold the upper 256 bits into the lower eight words.
module sm2r_column_sum
   import sm2r_pkg::*;
(
   input  logic [IN_W-1:0] value,
   output col_type         col [NWORDS]
);

   always_comb begin
      col_type acc;
      col_type term;
      for (int i = 0; i < NWORDS; i++) begin
         acc = col_type'({6'b0, value[WORD_W*i +: WORD_W]});
         for (int j = 0; j < NWORDS; j++) begin
            term = col_type'({6'b0, value[LO_W + WORD_W*j +: WORD_W]});
            case (WEIGHT[i][j])
               1: acc = acc + term;
               2: acc = acc + (term <<< 1);
               3: acc = acc + (term <<< 1) + term;
               -1: acc = acc - term;
               -2: acc = acc - (term <<< 1);
               -3: acc = acc - (term <<< 1) - term;
               default: acc = acc;
            endcase
         end
         col[i] = acc;
      end
   end

endmodule
